>>> src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of aclk outside reset.
`define RPCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same check, used for the handshake rules.
`define RPCA_ASSERT_HS(label, prop, msg) \
    `RPCA_ASSERT(label, prop, msg)

`endif

>>> src/rpca_pkg.sv
// Package with constants, types and helpers of the row prime count unit.
`timescale 1ns / 1ps

package rpca_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int MAX_DIM     = 128;
    localparam int DIM_W       = 8;
    localparam int CNT_W       = 8;
    localparam int EFF_W       = DIM_W + 1;

    localparam int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * CNT_W + 7) / 8) * 8;

    localparam int DIV_STEPS   = 8;
    localparam int DIV_CYCLES  = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DVD_W       = DIV_CYCLES * DIV_STEPS;
    localparam int CYC_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int DIV_W       = VALUE_WIDTH / 2 + 2;
    localparam int SQ_W        = VALUE_WIDTH + 2;

    localparam logic [0:0] REG_ROW_COUNT = 1'b0;
    localparam logic [0:0] REG_COL_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_NEXT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    function automatic logic [EFF_W-1:0] effective_dim(input logic [DIM_W-1:0] reg_val);
        logic [EFF_W-1:0] ext;
        ext = {1'b0, reg_val};
        if (ext == '0) begin
            return EFF_W'(1);
        end else if (ext > EFF_W'(MAX_DIM)) begin
            return EFF_W'(MAX_DIM);
        end
        return ext;
    endfunction

endpackage

>>> src/row_prime_count_argmax_unit.sv
// Top level: trial division primality test with per-row prime count and best row.
// Negatives, values below 2, even values and odd values below 9 go from ST_IDLE to ST_FINISH.
// Larger odd values test odd divisors from 3 while d*d <= value, each through ST_DIV and
// ST_NEXT on the shared restoring divider (8 dividend bits per cycle).
// The result leaves through an output register, loaded in ST_FINISH of the last element.
// aresetn is synchronous and active low; it sets both dimensions to 1 and clears progress.
`timescale 1ns / 1ps

module row_prime_count_argmax_unit
    import rpca_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_addr,
    input  logic [DIM_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // {best_count, best_row}
);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]       row_count_reg, col_count_reg;
    logic [CNT_W-1:0]       col_pos_reg, col_pos_next;
    logic [CNT_W-1:0]       row_pos_reg, row_pos_next;
    logic [CNT_W-1:0]       row_primes_reg, row_primes_next;
    logic [CNT_W-1:0]       max_primes_reg, max_primes_next;
    logic [CNT_W-1:0]       max_row_reg, max_row_next;

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [DVD_W-1:0]       dvd_reg, dvd_next;
    logic [DIV_W:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [CYC_W-1:0]       cyc_reg, cyc_next;
    logic                   prime_reg, prime_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [DIV_W:0]         step_rem;
    logic [DVD_W-1:0]       step_dvd;
    logic [DIV_W-1:0]       cand_div;
    logic [SQ_W-1:0]        cand_sq;
    logic [EFF_W-1:0]       rows_eff, cols_eff;
    logic [CNT_W-1:0]       col_inc, row_inc, primes_inc;
    logic                   row_end, mat_end;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        logic [DIV_W:0]   r;
        logic [DVD_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            r = {r[DIV_W-1:0], d[DVD_W-1]};
            d = {d[DVD_W-2:0], 1'b0};
            if (r >= {1'b0, div_reg}) begin
                r = r - {1'b0, div_reg};
            end
        end
        step_rem = r;
        step_dvd = d;
    end

    assign cand_div = div_reg + DIV_W'(2);
    assign cand_sq  = sq_reg + SQ_W'({div_reg, 2'b00}) + SQ_W'(4);

    assign rows_eff   = effective_dim(row_count_reg);
    assign cols_eff   = effective_dim(col_count_reg);
    assign primes_inc = prime_reg ? row_primes_reg + CNT_W'(1) : row_primes_reg;
    assign col_inc    = col_pos_reg + CNT_W'(1);
    assign row_inc    = row_pos_reg + CNT_W'(1);
    assign row_end    = ({1'b0, col_inc} >= cols_eff);
    assign mat_end    = row_end && ({1'b0, row_inc} >= rows_eff);

    always_comb begin
        state_next      = state_reg;
        value_next      = value_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        sq_next         = sq_reg;
        cyc_next        = cyc_reg;
        prime_next      = prime_reg;
        col_pos_next    = col_pos_reg;
        row_pos_next    = row_pos_reg;
        row_primes_next = row_primes_reg;
        max_primes_next = max_primes_reg;
        max_row_next    = max_row_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = in_value;
                    dvd_next   = DVD_W'(in_value);
                    rem_next   = '0;
                    div_next   = DIV_W'(3);
                    sq_next    = SQ_W'(9);
                    cyc_next   = CYC_W'(DIV_CYCLES - 1);
                    if (in_value[VALUE_WIDTH-1] || in_value < VALUE_WIDTH'(2)) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else if (!in_value[0]) begin
                        prime_next = (in_value == VALUE_WIDTH'(2));
                        state_next = ST_FINISH;
                    end else if (SQ_W'(in_value) < SQ_W'(9)) begin
                        prime_next = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = step_rem;
                dvd_next = step_dvd;
                cyc_next = cyc_reg - CYC_W'(1);
                if (cyc_reg == '0) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (rem_reg == '0) begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end else if (cand_sq > SQ_W'(value_reg)) begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    div_next   = cand_div;
                    sq_next    = cand_sq;
                    dvd_next   = DVD_W'(value_reg);
                    rem_next   = '0;
                    cyc_next   = CYC_W'(DIV_CYCLES - 1);
                    state_next = ST_DIV;
                end
            end
            ST_FINISH: begin
                if (!(mat_end && m_tvalid_reg && !m_tready)) begin
                    state_next = ST_IDLE;
                    if (!row_end) begin
                        col_pos_next    = col_inc;
                        row_primes_next = primes_inc;
                    end else begin
                        col_pos_next    = '0;
                        row_primes_next = '0;
                        row_pos_next    = row_inc;
                        if (primes_inc > max_primes_reg) begin
                            max_primes_next = primes_inc;
                            max_row_next    = row_inc;
                        end
                        if (mat_end) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = M_TDATA_W'({max_primes_next, max_row_next});
                            row_pos_next    = '0;
                            max_primes_next = '0;
                            max_row_next    = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_count_reg  <= DIM_W'(1);
            col_count_reg  <= DIM_W'(1);
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            row_primes_reg <= '0;
            max_primes_reg <= '0;
            max_row_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_pos_reg    <= col_pos_next;
            row_pos_reg    <= row_pos_next;
            row_primes_reg <= row_primes_next;
            max_primes_reg <= max_primes_next;
            max_row_reg    <= max_row_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ROW_COUNT: row_count_reg <= cfg_wr_data;
                    REG_COL_COUNT: col_count_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        cyc_reg     <= cyc_next;
        prime_reg   <= prime_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> src/rpca_checker.sv
// Port-level checker for the row prime count unit and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpca_checker
    import rpca_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic out_stall;
    logic row_zero;
    logic count_zero;

    assign out_stall  = m_tvalid && !m_tready;
    assign row_zero   = (m_tdata[CNT_W-1:0] == '0);
    assign count_zero = (m_tdata[2*CNT_W-1:CNT_W] == '0);

    `RPCA_ASSERT_HS(a_out_hold, out_stall |=> m_tvalid, "result dropped while stalled")
    `RPCA_ASSERT_HS(a_out_stable, out_stall |=> $stable(m_tdata), "stalled result changed")
    `RPCA_ASSERT(a_busy_after_take, s_tvalid && s_tready |=> !s_tready, "item taken without busy cycle")
    `RPCA_ASSERT(a_row_count_pair, m_tvalid |-> (row_zero == count_zero), "best row and count disagree")

endmodule

bind row_prime_count_argmax_unit rpca_checker u_rpca_checker (.*);
